// ----- hdl/bpc_pkg.sv -----
package bpc_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_AC1     = 3'd0,
    REG_AC2     = 3'd1,
    REG_AC3     = 3'd2,
    REG_AC4     = 3'd3,
    REG_AC5_AC6 = 3'd4,
    REG_B1_B2   = 3'd5,
    REG_MC_MD   = 3'd6,
    REG_OSS     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
  } in_t;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    status_e            status;
  } out_t;

  // temperature result and error flags carried down the pipe
  typedef struct packed {
    logic [11:0] tval;
    logic        tsat;
    logic        dz;
  } side_t;

  localparam int          CfgW      = 32;
  localparam logic [31:0] B6Off     = 32'd4000;
  localparam logic [31:0] B4Off     = 32'd32768;
  localparam logic [31:0] B7Scale   = 32'd50000;
  localparam logic [31:0] PC1       = 32'd3038;
  localparam logic [31:0] PC2       = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PC3       = 32'd3791;
  localparam logic signed [31:0] TMin = -32'sd2048;
  localparam logic signed [31:0] TMax = 32'sd2047;
  localparam logic signed [31:0] PMax = 32'sd1048575;

endpackage

// ----- hdl/bpc_div.sv -----
module bpc_div #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [W-1:0]  divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quotient_o,
  output logic [SW-1:0] side_o
);

  logic [W-1:0]  rem_q [W];
  logic [W-1:0]  acc_q [W];
  logic [W-1:0]  dsr_q [W];
  logic [SW-1:0] sd_q  [W];
  logic [W-1:0]  rem_d [W];
  logic [W-1:0]  acc_d [W];
  logic [W-1:0]  vld_q;

  // one restoring step per stage, quotient bits shift in behind the dividend
  always_comb begin
    logic [W-1:0] rem_in;
    logic [W-1:0] acc_in;
    logic [W-1:0] dsr_in;
    logic [W:0]   trial;
    logic [W:0]   diff;
    for (int i = 0; i < W; i++) begin
      if (i == 0) begin
        rem_in = '0;
        acc_in = dividend_i;
        dsr_in = divisor_i;
      end else begin
        rem_in = rem_q[i-1];
        acc_in = acc_q[i-1];
        dsr_in = dsr_q[i-1];
      end
      trial    = {rem_in, acc_in[W-1]};
      diff     = trial - {1'b0, dsr_in};
      rem_d[i] = diff[W] ? trial[W-1:0] : diff[W-1:0];
      acc_d[i] = {acc_in[W-2:0], ~diff[W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < W; i++) begin
        rem_q[i] <= rem_d[i];
        acc_q[i] <= acc_d[i];
        if (i == 0) begin
          dsr_q[i] <= divisor_i;
          sd_q[i]  <= side_i;
        end else begin
          dsr_q[i] <= dsr_q[i-1];
          sd_q[i]  <= sd_q[i-1];
        end
      end
    end
  end

  assign valid_o    = vld_q[W-1];
  assign quotient_o = acc_q[W-1];
  assign side_o     = sd_q[W-1];

endmodule

// ----- hdl/barometric_pressure_compensation.sv -----
// barometric pressure and temperature compensation
//
// input channel: in_valid_i / in_ready_o with in_data_i (raw temperature word and
// the three raw pressure bytes). output channel: out_valid_o / out_ready_i with
// out_data_o (temperature in tenths of a degree, pressure in pascals, status).
// calibration and oversampling must be written via cfg_we_i / cfg_idx_i / cfg_data_i
// only with no beat in flight, unchecked by the block; writes take effect at once.
//
// two pipelined 32-step restoring dividers (one quotient bit per stage) dominate
// the pipe, plus 13 arithmetic stages holding 32-bit multiplies or short add chains.
// throughput is one beat per cycle unless the receiver stalls.
//
// reset clears all calibration registers and every stage valid bit.
// the whole pipe advances together; when the receiver stalls with a beat waiting
// in the output register, every stage holds and in_ready_o drops until the
// waiting beat is taken. nothing is lost or repeated.
module barometric_pressure_compensation (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpc_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpc_pkg::out_t     out_data_o,
  input  logic              cfg_we_i,
  input  bpc_pkg::cfg_idx_e cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import bpc_pkg::*;

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q;
  logic [31:0] ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q  <= '0;
      ac2_q  <= '0;
      ac3_q  <= '0;
      ac4_q  <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AC1:     ac1_q  <= cfg_data_i[15:0];
        REG_AC2:     ac2_q  <= cfg_data_i[15:0];
        REG_AC3:     ac3_q  <= cfg_data_i[15:0];
        REG_AC4:     ac4_q  <= cfg_data_i[15:0];
        REG_AC5_AC6: ac56_q <= cfg_data_i;
        REG_B1_B2:   b12_q  <= cfg_data_i;
        REG_MC_MD:   mcmd_q <= cfg_data_i;
        REG_OSS:     oss_q  <= cfg_data_i[1:0];
        default:     ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac1_q[15]}}, ac1_q};
  assign ac2 = {{16{ac2_q[15]}}, ac2_q};
  assign ac3 = {{16{ac3_q[15]}}, ac3_q};
  assign ac4 = {16'd0, ac4_q};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = {{16{b12_q[31]}}, b12_q[31:16]};
  assign b2  = {{16{b12_q[15]}}, b12_q[15:0]};
  assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
  assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: raw temperature term, pressure word
  logic        s1_vld_q;
  logic [31:0] s1_x1_q;
  logic [23:0] s1_up_q;
  logic [31:0] s1_prod;
  logic [23:0] s1_up;
  assign s1_prod = ({16'd0, in_data_i.raw_temperature} - ac6) * ac5;
  assign s1_up   = in_data_i.raw_pressure_bytes >> (4'd8 - {2'd0, oss_q});

  // stage 2: divisor and operand magnitudes
  logic        s2_vld_q, s2_neg_q, s2_dz_q;
  logic [31:0] s2_ua_q, s2_ub_q, s2_x1_q;
  logic [23:0] s2_up_q;
  logic [31:0] s2_den, s2_num;
  assign s2_den = s1_x1_q + md;
  assign s2_num = {mc[20:0], 11'd0};

  // first divider
  logic        d1_vld;
  logic [31:0] d1_q;
  logic [57:0] d1_side;
  logic [31:0] d1_x1;
  logic [23:0] d1_up;
  logic        d1_neg, d1_dz;

  bpc_div #(.W(32), .SW(58)) u_div_temp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s2_vld_q),
    .dividend_i(s2_ua_q),
    .divisor_i (s2_ub_q),
    .side_i    ({s2_x1_q, s2_up_q, s2_neg_q, s2_dz_q}),
    .valid_o   (d1_vld),
    .quotient_o(d1_q),
    .side_o    (d1_side)
  );
  assign {d1_x1, d1_up, d1_neg, d1_dz} = d1_side;

  // stage 3: b5
  logic        s3_vld_q, s3_dz_q;
  logic [31:0] s3_b5_q;
  logic [23:0] s3_up_q;

  // stage 4: b6 and saturated temperature
  logic        s4_vld_q;
  logic [31:0] s4_b6_q;
  logic [23:0] s4_up_q;
  side_t       s4_sd_q;
  logic signed [31:0] s4_t;
  assign s4_t = $signed(s3_b5_q + 32'd8) >>> 4;

  // stage 5: products of b6
  logic        s5_vld_q;
  logic [31:0] s5_sq_q, s5_x2a_q, s5_x1c_q;
  logic [23:0] s5_up_q;
  side_t       s5_sd_q;
  logic [31:0] s5_m0, s5_m1, s5_m2;
  assign s5_m0 = s4_b6_q * s4_b6_q;
  assign s5_m1 = ac2 * s4_b6_q;
  assign s5_m2 = ac3 * s4_b6_q;

  // stage 6: products of the square
  logic        s6_vld_q;
  logic [31:0] s6_x1a_q, s6_x2a_q, s6_x1c_q, s6_x2c_q;
  logic [23:0] s6_up_q;
  side_t       s6_sd_q;
  logic [31:0] s6_m0, s6_m1;
  assign s6_m0 = b2 * s5_sq_q;
  assign s6_m1 = b1 * s5_sq_q;

  // stage 7: b3 numerator and x3
  logic        s7_vld_q;
  logic [31:0] s7_v_q, s7_x3_q;
  logic [23:0] s7_up_q;
  side_t       s7_sd_q;
  logic [31:0] s7_v, s7_c;
  assign s7_v = ((({ac1[29:0], 2'd0}) + s6_x1a_q + s6_x2a_q) << oss_q) + 32'd2;
  assign s7_c = s6_x1c_q + s6_x2c_q + 32'd2;

  // stage 8: b3 and b4
  logic        s8_vld_q;
  logic [31:0] s8_b3_q, s8_b4_q;
  logic [23:0] s8_up_q;
  side_t       s8_sd_q;
  logic [31:0] s8_m;
  logic [31:0] s8_b3;
  assign s8_m  = ac4 * (s7_x3_q + B4Off);
  assign s8_b3 = s7_v_q[31] ? 32'($signed(s7_v_q + 32'd3) >>> 2)
                            : 32'($signed(s7_v_q) >>> 2);

  // stage 9: b7
  logic        s9_vld_q;
  logic [31:0] s9_b7_q, s9_b4_q;
  side_t       s9_sd_q;
  logic [31:0] s9_b7;
  assign s9_b7 = ({8'd0, s8_up_q} - s8_b3_q) * (B7Scale >> oss_q);

  // second divider
  logic        d2_vld;
  logic [31:0] d2_q;
  logic [14:0] d2_side;
  logic        d2_hi;
  side_t       d2_sd;

  bpc_div #(.W(32), .SW(15)) u_div_pres (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s9_vld_q),
    .dividend_i(s9_b7_q[31] ? s9_b7_q : {s9_b7_q[30:0], 1'b0}),
    .divisor_i (s9_b4_q),
    .side_i    ({s9_b7_q[31], s9_sd_q}),
    .valid_o   (d2_vld),
    .quotient_o(d2_q),
    .side_o    (d2_side)
  );
  assign {d2_hi, d2_sd} = d2_side;

  // stage 10 to 12: pressure correction
  logic        s10_vld_q, s11_vld_q, s12_vld_q;
  logic [31:0] s10_p_q, s11_p_q, s12_p_q;
  logic [31:0] s11_x1_q, s11_x2_q, s12_x1_q, s12_x2_q;
  side_t       s10_sd_q, s11_sd_q, s12_sd_q;
  logic [31:0] s11_pd8, s11_sq, s11_m, s12_m;
  assign s11_pd8 = 32'($signed(s10_p_q) >>> 8);
  assign s11_sq  = s11_pd8 * s11_pd8;
  assign s11_m   = PC2 * s10_p_q;
  assign s12_m   = s11_x1_q * PC1;

  // output stage
  logic signed [31:0] o_p;
  logic               o_psat;
  out_t               o_d;
  out_t               out_q;
  logic               out_vld_q;
  assign o_p = $signed(s12_p_q + 32'($signed(s12_x1_q + s12_x2_q + PC3) >>> 4));

  always_comb begin
    o_d        = '0;
    o_psat     = 1'b0;
    o_d.status = ST_OK;
    if (o_p < 0) begin
      o_psat        = 1'b1;
      o_d.pressure_pa = '0;
    end else if (o_p > PMax) begin
      o_psat        = 1'b1;
      o_d.pressure_pa = PMax[19:0];
    end else begin
      o_d.pressure_pa = o_p[19:0];
    end
    o_d.temperature_tenths = s12_sd_q.tval;
    if (s12_sd_q.dz) begin
      o_d.pressure_pa        = '0;
      o_d.temperature_tenths = '0;
      o_d.status             = ST_DIV_ZERO;
    end else if (o_psat || s12_sd_q.tsat) begin
      o_d.status = ST_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= d1_vld;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= d2_vld;
      s11_vld_q <= s10_vld_q;
      s12_vld_q <= s11_vld_q;
      out_vld_q <= s12_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x1_q  <= 32'($signed(s1_prod) >>> 15);
      s1_up_q  <= s1_up;

      s2_dz_q  <= (s2_den == '0);
      s2_neg_q <= s2_num[31] ^ s2_den[31];
      s2_ua_q  <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
      s2_ub_q  <= s2_den[31] ? (32'd0 - s2_den) : s2_den;
      s2_x1_q  <= s1_x1_q;
      s2_up_q  <= s1_up_q;

      s3_b5_q  <= d1_x1 + (d1_neg ? (32'd0 - d1_q) : d1_q);
      s3_up_q  <= d1_up;
      s3_dz_q  <= d1_dz;

      s4_b6_q      <= s3_b5_q - B6Off;
      s4_up_q      <= s3_up_q;
      s4_sd_q.dz   <= s3_dz_q;
      s4_sd_q.tsat <= (s4_t < TMin) || (s4_t > TMax);
      s4_sd_q.tval <= (s4_t < TMin) ? TMin[11:0] : (s4_t > TMax) ? TMax[11:0] : s4_t[11:0];

      s5_sq_q  <= 32'($signed(s5_m0) >>> 12);
      s5_x2a_q <= 32'($signed(s5_m1) >>> 11);
      s5_x1c_q <= 32'($signed(s5_m2) >>> 13);
      s5_up_q  <= s4_up_q;
      s5_sd_q  <= s4_sd_q;

      s6_x1a_q <= 32'($signed(s6_m0) >>> 11);
      s6_x2c_q <= 32'($signed(s6_m1) >>> 16);
      s6_x2a_q <= s5_x2a_q;
      s6_x1c_q <= s5_x1c_q;
      s6_up_q  <= s5_up_q;
      s6_sd_q  <= s5_sd_q;

      s7_v_q   <= s7_v;
      s7_x3_q  <= 32'($signed(s7_c) >>> 2);
      s7_up_q  <= s6_up_q;
      s7_sd_q  <= s6_sd_q;

      s8_b3_q  <= s8_b3;
      s8_b4_q  <= {15'd0, s8_m[31:15]};
      s8_up_q  <= s7_up_q;
      s8_sd_q  <= s7_sd_q;

      s9_b7_q      <= s9_b7;
      s9_b4_q      <= s8_b4_q;
      s9_sd_q.tval <= s8_sd_q.tval;
      s9_sd_q.tsat <= s8_sd_q.tsat;
      s9_sd_q.dz   <= s8_sd_q.dz || (s8_b4_q == '0);

      s10_p_q  <= d2_hi ? {d2_q[30:0], 1'b0} : d2_q;
      s10_sd_q <= d2_sd;

      s11_x1_q <= s11_sq;
      s11_x2_q <= 32'($signed(s11_m) >>> 16);
      s11_p_q  <= s10_p_q;
      s11_sd_q <= s10_sd_q;

      s12_x1_q <= 32'($signed(s12_m) >>> 16);
      s12_x2_q <= s11_x2_q;
      s12_p_q  <= s11_p_q;
      s12_sd_q <= s11_sd_q;

      out_q    <= o_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_DIV_ZERO) |->
      (out_data_o.pressure_pa == '0) && (out_data_o.temperature_tenths == '0))
    else $error("zero divisor beat carries non-zero results");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s12_vld_q) && $stable(s1_vld_q))
    else $error("pipe moved while stalled");
  a_div2_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld && en |=> s10_vld_q)
    else $error("divider result dropped");
`endif

endmodule
